[hw/rtl/nbg_pkg.sv]
// ----------------------------------------------------------------------------
// nbg_pkg: shared types and constants for the n-body gravity step block
// Particle record, item and result beats, register indexes, saturation helper.
// ----------------------------------------------------------------------------
package nbg_pkg;

  localparam int MAX_PARTICLES = 128;
  localparam int ADDR_W        = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

  localparam logic [10:0] SCALE_CAP = 11'd1024;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_STEP = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_GRAV_CONST  = 3'd0,
    REG_FORCE_LIMIT = 3'd1,
    REG_TIME_STEP   = 3'd2,
    REG_DIST_SCALE  = 3'd3,
    REG_MIN_DIST_SQ = 3'd4,
    REG_ACTIVE_CNT  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [6:0]         index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        mass;
  } item_t;

  typedef struct packed {
    logic               step_done;
    logic [6:0]         out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
  } result_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [15:0]        mass;
  } particle_t;

  // settings the pair unit needs, scale already capped
  typedef struct packed {
    logic [31:0] grav;
    logic [47:0] limit;
    logic [10:0] scale;
    logic [31:0] min_d2;
  } pair_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[hw/rtl/nbg_ram.sv]
// ----------------------------------------------------------------------------
// nbg_ram: particle store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module nbg_ram import nbg_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  particle_t         wdata,
  input  logic [ADDR_W-1:0] raddr,
  output particle_t         rdata
);

  particle_t mem [MAX_PARTICLES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/nbg_div.sv]
// ----------------------------------------------------------------------------
// nbg_div: serial unsigned divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nbg_div import nbg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [32:0] rsh;
  logic [32:0] rsub;
  logic        ge;

  always_comb begin
    rsh  = {rem, dvd[63]};
    ge   = rsh >= {1'b0, dsr};
    rsub = rsh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[62:0], ge};
      rem <= ge ? rsub[31:0] : rsh[31:0];
    end
  end

  assign quotient = dvd;

endmodule

[hw/rtl/nbg_pair.sv]
// ----------------------------------------------------------------------------
// nbg_pair: pair force unit
// Scaled distance, skip test, clamped force quotient, square root and the
// two direction components of one particle pair.
// ----------------------------------------------------------------------------
module nbg_pair import nbg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pair_cfg_t          cfg,
  input  logic signed [31:0] xi,
  input  logic signed [31:0] yi,
  input  logic [15:0]        mi,
  input  logic signed [31:0] xj,
  input  logic signed [31:0] yj,
  input  logic [15:0]        mj,
  output logic               done,
  output logic signed [49:0] cx,
  output logic signed [49:0] cy
);

  typedef enum logic [3:0] {
    P_IDLE, P_SCALE, P_SQX, P_SQY, P_CHK, P_FDIV, P_CLAMP, P_SQRT,
    P_USTART, P_UDIV, P_MUL0, P_MUL1
  } pstate_t;

  pstate_t            state;
  logic signed [32:0] dx, dy;
  logic [31:0]        mm;
  logic [30:0]        ax, ay;
  logic [61:0]        sqx, d2;
  logic [95:0]        num;
  logic [61:0]        rr;
  logic [48:0]        q;
  logic               big;
  logic [6:0]         cnt;
  logic [47:0]        force_mag;
  logic [61:0]        sn, rt, bitm;
  logic               axis;
  logic [32:0]        u;
  logic [56:0]        plo;

  logic [32:0]        adx, ady;
  logic [43:0]        sxp, syp;
  logic               skip;
  logic [62:0]        rsh, rdiff;
  logic               fge;
  logic [62:0]        trial;
  logic               sge;
  logic [56:0]        phi;
  logic [80:0]        acc;
  logic [48:0]        cmag;
  logic signed [49:0] cval;
  logic               div_start, div_done;
  logic [63:0]        div_q;

  always_comb begin
    adx   = dx[32] ? 33'(-dx) : 33'(dx);
    ady   = dy[32] ? 33'(-dy) : 33'(dy);
    sxp   = 44'(adx) * 44'(cfg.scale);
    syp   = 44'(ady) * 44'(cfg.scale);
    skip  = (d2 == '0) ||
            ((d2[61:32] == '0) && ({d2[31:0], 16'b0} < {16'b0, cfg.min_d2}));
    rsh   = {rr, num[95]};
    fge   = rsh >= {1'b0, d2};
    rdiff = rsh - {1'b0, d2};
    trial = {1'b0, rt} + {1'b0, bitm};
    sge   = {1'b0, sn} >= trial;
    phi   = 57'(force_mag[47:24]) * 57'(u);
    acc   = {24'b0, plo} + {phi, 24'b0};
    cmag  = acc[80:32];
    if ((axis ? dy[32] : dx[32])) cval = -$signed({1'b0, cmag});
    else cval = $signed({1'b0, cmag});
  end

  assign div_start = (state == P_USTART);

  nbg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (axis ? {1'b0, ay, 32'b0} : {1'b0, ax, 32'b0}),
    .divisor  (rt[31:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        P_IDLE: begin
          if (start) begin
            dx    <= {xj[31], xj} - {xi[31], xi};
            dy    <= {yj[31], yj} - {yi[31], yi};
            mm    <= 32'(mi) * 32'(mj);
            state <= P_SCALE;
          end
        end
        P_SCALE: begin
          ax    <= sxp[42:12];
          ay    <= syp[42:12];
          state <= P_SQX;
        end
        P_SQX: begin
          sqx   <= 62'(ax) * 62'(ax);
          state <= P_SQY;
        end
        P_SQY: begin
          d2    <= sqx + 62'(ay) * 62'(ay);
          state <= P_CHK;
        end
        P_CHK: begin
          if (skip) begin
            cx    <= '0;
            cy    <= '0;
            done  <= 1'b1;
            state <= P_IDLE;
          end else begin
            num   <= {64'(cfg.grav) * 64'(mm), 32'b0};
            rr    <= '0;
            q     <= '0;
            big   <= 1'b0;
            cnt   <= 7'd95;
            state <= P_FDIV;
          end
        end
        P_FDIV: begin
          rr  <= fge ? rdiff[61:0] : rsh[61:0];
          num <= {num[94:0], 1'b0};
          if (q[48]) big <= 1'b1;
          else q <= {q[47:0], fge};
          cnt <= cnt - 7'd1;
          if (cnt == '0) state <= P_CLAMP;
        end
        P_CLAMP: begin
          force_mag <= (big || (q > {1'b0, cfg.limit})) ? cfg.limit : q[47:0];
          sn        <= d2;
          rt        <= '0;
          bitm      <= 62'(1) << 60;
          state     <= P_SQRT;
        end
        P_SQRT: begin
          if (sge) begin
            sn <= sn - trial[61:0];
            rt <= (rt >> 1) + bitm;
          end else begin
            rt <= rt >> 1;
          end
          bitm <= bitm >> 2;
          if (bitm[0]) begin
            axis  <= 1'b0;
            state <= P_USTART;
          end
        end
        P_USTART: state <= P_UDIV;
        P_UDIV: begin
          if (div_done) begin
            u     <= div_q[32:0];
            state <= P_MUL0;
          end
        end
        P_MUL0: begin
          plo   <= 57'(force_mag[23:0]) * 57'(u);
          state <= P_MUL1;
        end
        P_MUL1: begin
          if (axis) begin
            cy    <= cval;
            done  <= 1'b1;
            state <= P_IDLE;
          end else begin
            cx    <= cval;
            axis  <= 1'b1;
            state <= P_USTART;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/nbody_gravity_step.sv]
// ----------------------------------------------------------------------------
// nbody_gravity_step: direct-sum 2-D gravity over a particle store
// Loads, reads and in-place semi-implicit Euler substeps on Q4.28 particles.
// ----------------------------------------------------------------------------
//
//  channel   handshake              beat
//  -------   ---------------------  ----------------------------------------
//  item      item_valid/item_stall  kind, index, position, velocity, mass
//  result    result_valid/stall     step_done, index, position, velocity
//  cfg       cfg_valid/cfg_ready    cfg_index (register), cfg_data
//
// A load is written to the store as it is accepted. A read passes T_RD and
// T_OUT to the result register. A step runs rows and pairs through the serial
// force quotient, the square root and the serial divider used per direction
// component and per velocity axis, with one pair in flight.
// Synchronous reset clears control and loads the register defaults; the
// particle store is not cleared. item_stall is high while an item is in work;
// a finished result waits in its state until the result register is free.
// ----------------------------------------------------------------------------
module nbody_gravity_step import nbg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  typedef enum logic [4:0] {
    T_IDLE, T_RD, T_OUT, T_ROW_RD, T_ROW_LAT, T_PAIR_RD, T_PAIR_GO,
    T_PAIR_WAIT, T_VEL, T_VM0, T_VM1, T_VM2, T_VDS, T_VDW, T_PX, T_PY, T_WB
  } tstate_t;

  // configuration registers
  logic [31:0] grav_const;
  logic [47:0] force_limit;
  logic [31:0] time_step;
  logic [10:0] distance_scale;
  logic [31:0] min_dist_sq;
  logic [7:0]  active_count;

  tstate_t            state;
  logic [CNT_W-1:0]   i, j, n;
  particle_t          pi;          // working copy of the row particle
  logic signed [56:0] fx, fy;
  logic               axis;
  logic               fneg;
  logic [55:0]        fmag;
  logic [59:0]        vlo;
  logic [63:0]        tv;
  logic [6:0]         rd_index;
  logic               rd_ok;
  result_t            res_pend;

  // memory ports
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  particle_t         wdata, rdata;

  logic              accept;
  logic              slot_ok;
  logic [CNT_W-1:0]  n_eff;
  pair_cfg_t         pcfg;
  logic              pair_start, pair_done;
  logic signed [49:0] cx, cy;
  logic              div_start, div_done;
  logic [63:0]       div_q;

  logic signed [56:0] fsel;
  logic [59:0]        vhi;
  logic [87:0]        vprod;
  logic [36:0]        dv;
  logic signed [39:0] dvs;
  logic signed [31:0] vsel, psel;
  logic signed [39:0] vsum;
  logic [31:0]        vmag;
  logic [63:0]        pm;
  logic signed [39:0] psum;

  assign accept    = item_valid && !item_stall;
  assign item_stall = (state != T_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_ok   = ({25'b0, item.index} < 32'(MAX_PARTICLES));
  assign n_eff     = (32'(active_count) > MAX_PARTICLES) ? CNT_W'(MAX_PARTICLES)
                                                        : CNT_W'(active_count);

  always_comb begin
    pcfg.grav   = grav_const;
    pcfg.limit  = force_limit;
    pcfg.scale  = (distance_scale > SCALE_CAP) ? SCALE_CAP : distance_scale;
    pcfg.min_d2 = min_dist_sq;
  end

  // config writes, any index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_const     <= 32'd28147498;
      force_limit    <= 48'd281474976711;
      time_step      <= 32'd42949673;
      distance_scale <= 11'd100;
      min_dist_sq    <= 32'd281474977;
      active_count   <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRAV_CONST:  grav_const     <= cfg_data[31:0];
        REG_FORCE_LIMIT: force_limit    <= cfg_data;
        REG_TIME_STEP:   time_step      <= cfg_data[31:0];
        REG_DIST_SCALE:  distance_scale <= cfg_data[10:0];
        REG_MIN_DIST_SQ: min_dist_sq    <= cfg_data[31:0];
        REG_ACTIVE_CNT:  active_count   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Store access. Every access is issued by the sequencer one at a time, so a
  // row write-back always lands before any later read of that slot.
  always_comb begin
    we    = 1'b0;
    waddr = i[ADDR_W-1:0];
    wdata = pi;
    raddr = j[ADDR_W-1:0];
    case (state)
      T_IDLE: begin
        raddr = ADDR_W'(item.index);
        waddr = ADDR_W'(item.index);
        wdata.x    = item.pos_x;
        wdata.y    = item.pos_y;
        wdata.vx   = item.vel_x;
        wdata.vy   = item.vel_y;
        wdata.mass = item.mass;
        we = accept && (item.kind == KIND_LOAD) && slot_ok;
      end
      T_ROW_RD: raddr = i[ADDR_W-1:0];
      T_WB:     we = 1'b1;
      default: ;
    endcase
  end

  nbg_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pair_start = (state == T_PAIR_GO);

  nbg_pair u_pair (
    .clk   (clk),
    .rst   (rst),
    .start (pair_start),
    .cfg   (pcfg),
    .xi    (pi.x),
    .yi    (pi.y),
    .mi    (pi.mass),
    .xj    (rdata.x),
    .yj    (rdata.y),
    .mj    (rdata.mass),
    .done  (pair_done),
    .cx    (cx),
    .cy    (cy)
  );

  assign div_start = (state == T_VDS);

  // velocity divide by the particle mass
  nbg_div u_vdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tv),
    .divisor  ({16'b0, pi.mass}),
    .done     (div_done),
    .quotient (div_q)
  );

  // velocity and position datapath
  always_comb begin
    fsel  = axis ? fy : fx;
    vhi   = 60'(fmag[55:28]) * 60'(time_step);
    vprod = {28'b0, vlo} + {vhi, 28'b0};
    dv    = div_q[52:16];
    dvs   = fneg ? -$signed({3'b0, dv}) : $signed({3'b0, dv});
    vsel  = axis ? pi.vy : pi.vx;
    vsum  = {{8{vsel[31]}}, vsel} + dvs;
    psel  = (state == T_PY) ? pi.vy : pi.vx;
    vmag  = psel[31] ? 32'(-{psel[31], psel}) : psel;
    pm    = 64'(vmag) * 64'(time_step);
    if (psel[31]) psum = -$signed({8'b0, pm[63:32]});
    else psum = $signed({8'b0, pm[63:32]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      result_valid <= 1'b0;
    end else begin
      // T_OUT refills the result register itself
      if (result_valid && !result_stall && state != T_OUT) result_valid <= 1'b0;
      case (state)
        T_IDLE: begin
          if (accept) begin
            case (item.kind)
              KIND_READ: begin
                rd_index <= item.index;
                rd_ok    <= slot_ok;
                state    <= T_RD;
              end
              KIND_STEP: begin
                res_pend <= '{step_done: 1'b1, out_index: '0, out_pos_x: '0,
                              out_pos_y: '0, out_vel_x: '0, out_vel_y: '0};
                n <= n_eff;
                i <= '0;
                if (n_eff == '0) state <= T_OUT;
                else state <= T_ROW_RD;
              end
              default: ;   // loads finish here, unused kind is dropped
            endcase
          end
        end
        T_RD: begin
          res_pend <= '{step_done: 1'b0,
                        out_index: rd_index,
                        out_pos_x: rd_ok ? rdata.x : '0,
                        out_pos_y: rd_ok ? rdata.y : '0,
                        out_vel_x: rd_ok ? rdata.vx : '0,
                        out_vel_y: rd_ok ? rdata.vy : '0};
          state <= T_OUT;
        end
        T_OUT: begin
          if (!result_valid || !result_stall) begin
            result       <= res_pend;
            result_valid <= 1'b1;
            state        <= T_IDLE;
          end
        end
        T_ROW_RD: begin
          fx    <= '0;
          fy    <= '0;
          j     <= '0;
          state <= T_ROW_LAT;
        end
        T_ROW_LAT: begin
          pi    <= rdata;
          state <= T_PAIR_RD;
        end
        T_PAIR_RD: begin
          if (j == n) state <= T_VEL;
          else if (j == i) j <= j + 1'b1;
          else state <= T_PAIR_GO;
        end
        T_PAIR_GO: state <= T_PAIR_WAIT;
        T_PAIR_WAIT: begin
          if (pair_done) begin
            fx    <= fx + {{7{cx[49]}}, cx};
            fy    <= fy + {{7{cy[49]}}, cy};
            j     <= j + 1'b1;
            state <= T_PAIR_RD;
          end
        end
        T_VEL: begin
          axis <= 1'b0;
          // massless particle keeps its velocity
          if (pi.mass == '0) state <= T_PX;
          else state <= T_VM0;
        end
        T_VM0: begin
          fneg  <= fsel[56];
          fmag  <= fsel[56] ? 56'(-fsel) : fsel[55:0];
          state <= T_VM1;
        end
        T_VM1: begin
          vlo   <= 60'(fmag[27:0]) * 60'(time_step);
          state <= T_VM2;
        end
        T_VM2: begin
          tv    <= {12'b0, vprod[87:36]};
          state <= T_VDS;
        end
        T_VDS: state <= T_VDW;
        T_VDW: begin
          if (div_done) begin
            if (axis) begin
              pi.vy <= sat32(vsum);
              state <= T_PX;
            end else begin
              pi.vx <= sat32(vsum);
              axis  <= 1'b1;
              state <= T_VM0;
            end
          end
        end
        T_PX: begin
          pi.x  <= sat32({{8{pi.x[31]}}, pi.x} + psum);
          state <= T_PY;
        end
        T_PY: begin
          pi.y  <= sat32({{8{pi.y[31]}}, pi.y} + psum);
          state <= T_WB;
        end
        T_WB: begin
          i <= i + 1'b1;
          if (i + 1'b1 == n) state <= T_OUT;
          else state <= T_ROW_RD;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the n-body gravity step block
// A directed table, then random phases over several register settings. Every
// accepted item is fed to a local fixed-point model of the particle store.
// Each result beat is checked, field by field, against the oldest entry of the
// queue of expected particle reports.
// ----------------------------------------------------------------------------
module testbench;
  import nbg_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;   // not decoded, silently dropped
  localparam int         NSLOT       = 128;
  localparam int         MAX_REPORTS = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  nbody_gravity_step u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local model of the block: register copies and the particle store
  // --------------------------------------------------------------------------
  logic [31:0]        m_grav   = 32'd28147498;
  logic [47:0]        m_limit  = 48'd281474976711;
  logic [31:0]        m_dt     = 32'd42949673;
  logic [10:0]        m_scale  = 11'd100;
  logic [31:0]        m_min_d2 = 32'd281474977;
  logic [7:0]         m_count  = 8'd100;
  logic signed [31:0] m_x [NSLOT];
  logic signed [31:0] m_y [NSLOT];
  logic signed [31:0] m_vx[NSLOT];
  logic signed [31:0] m_vy[NSLOT];
  logic [15:0]        m_mass[NSLOT];
  bit                 loaded[NSLOT];

  result_t report_q[$];     // particle reports and step acks still owed
  int      mismatches = 0;
  int      tx_idle = 0;     // percent of cycles the item side sits idle
  int      rx_idle = 0;     // percent of cycles the result side stalls
  logic    hold_off = 1'b0; // long receiver hold-off, drives the block full
  logic    hold_go  = 1'b0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint apply_sign(input bit neg, input longint unsigned mag);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one substep, particles updated in slot order and in place
  function automatic void gravity_substep();
    longint unsigned scale, n, ax, ay, d2, dlen, num, fmag, u, cx, cy, t, mi;
    longint          ddx, ddy, fx, fy, vx, vy;
    logic [127:0]    wide;
    scale = (m_scale > SCALE_CAP) ? 64'd1024 : 64'(m_scale);
    n     = (m_count > NSLOT) ? NSLOT : 64'(m_count);
    for (int i = 0; i < n; i++) begin
      fx = 0;
      fy = 0;
      mi = 64'(m_mass[i]);
      for (int j = 0; j < n; j++) begin
        if (i == j) continue;
        ddx = longint'(m_x[j]) - longint'(m_x[i]);
        ddy = longint'(m_y[j]) - longint'(m_y[i]);
        ax  = ((ddx < 0 ? -ddx : ddx) * scale) >> 12;
        ay  = ((ddy < 0 ? -ddy : ddy) * scale) >> 12;
        d2  = ax * ax + ay * ay;
        if (d2 == 0) continue;
        if (d2 < (64'd1 << 32) && (d2 << 16) < 64'(m_min_d2)) continue;
        num  = 64'(m_grav) * (mi * 64'(m_mass[j]));
        wide = ({64'd0, num} << 32) / {64'd0, d2};
        fmag = (wide > 128'(m_limit)) ? 64'(m_limit) : wide[63:0];
        dlen = int_sqrt(d2);
        u    = (ax << 32) / dlen;
        wide = {64'd0, fmag} * {64'd0, u};
        cx   = wide[95:32];
        u    = (ay << 32) / dlen;
        wide = {64'd0, fmag} * {64'd0, u};
        cy   = wide[95:32];
        fx   = fx + apply_sign(ddx < 0, cx);
        fy   = fy + apply_sign(ddy < 0, cy);
      end
      if (mi != 0) begin
        wide     = {64'd0, 64'(fx < 0 ? -fx : fx)} * {96'd0, m_dt};
        t        = wide[99:36];
        m_vx[i]  = clamp32(longint'(m_vx[i]) + apply_sign(fx < 0, (t / mi) >> 16));
        wide     = {64'd0, 64'(fy < 0 ? -fy : fy)} * {96'd0, m_dt};
        t        = wide[99:36];
        m_vy[i]  = clamp32(longint'(m_vy[i]) + apply_sign(fy < 0, (t / mi) >> 16));
      end
      vx = longint'(m_vx[i]);
      vy = longint'(m_vy[i]);
      m_x[i] = clamp32(longint'(m_x[i]) +
                       apply_sign(vx < 0, ((vx < 0 ? -vx : vx) * 64'(m_dt)) >> 32));
      m_y[i] = clamp32(longint'(m_y[i]) +
                       apply_sign(vy < 0, ((vy < 0 ? -vy : vy) * 64'(m_dt)) >> 32));
    end
  endfunction

  // apply one item to the model; returns 1 when it owes a result beat
  function automatic bit predict_item(input item_t it, output result_t r);
    r = '0;
    case (it.kind)
      KIND_LOAD: begin
        m_x[it.index]    = it.pos_x;
        m_y[it.index]    = it.pos_y;
        m_vx[it.index]   = it.vel_x;
        m_vy[it.index]   = it.vel_y;
        m_mass[it.index] = it.mass;
        loaded[it.index] = 1'b1;
        return 1'b0;
      end
      KIND_STEP: begin
        gravity_substep();
        r.step_done = 1'b1;
        return 1'b1;
      end
      KIND_READ: begin
        r.out_index = it.index;
        r.out_pos_x = m_x[it.index];
        r.out_pos_y = m_y[it.index];
        r.out_vel_x = m_vx[it.index];
        r.out_vel_y = m_vy[it.index];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, long hold-off on request, field checks
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: %p", result);
      end else begin
        want = report_q.pop_front();
        if (result.step_done !== want.step_done || result.out_index !== want.out_index ||
            result.out_pos_x !== want.out_pos_x || result.out_pos_y !== want.out_pos_y ||
            result.out_vel_x !== want.out_vel_x || result.out_vel_y !== want.out_vel_y) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: exp %p got %p", want, result);
        end
      end
    end
    result_stall <= hold_off || ($urandom_range(99) < rx_idle);
  end

  // hold the result side for a long stretch while items keep coming
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Item side
  // --------------------------------------------------------------------------
  // Offer one beat; returns after the edge that takes it, valid still high.
  task automatic send_item(input item_t it, input bit typed, input result_t typed_r);
    result_t r;
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    if (predict_item(it, r)) report_q.push_back(typed ? typed_r : r);
  endtask

  task automatic send(input logic [1:0] k, input logic [6:0] idx,
                      input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] vx, input logic [31:0] vy,
                      input logic [15:0] m);
    item_t it;
    it = '{kind: k, index: idx, pos_x: x, pos_y: y, vel_x: vx, vel_y: vy, mass: m};
    send_item(it, 1'b0, '0);
  endtask

  // register write, only once the block has drained
  task automatic write_reg(input reg_idx_t r, input logic [47:0] v);
    item_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);   // a trailing load may still be in work
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (r)
      REG_GRAV_CONST:  m_grav   = v[31:0];
      REG_FORCE_LIMIT: m_limit  = v;
      REG_TIME_STEP:   m_dt     = v[31:0];
      REG_DIST_SCALE:  m_scale  = v[10:0];
      REG_MIN_DIST_SQ: m_min_d2 = v[31:0];
      REG_ACTIVE_CNT:  m_count  = v[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coord(input bit wide_range);
    return wide_range ? $urandom : 32'($signed($urandom) >>> 5);
  endfunction

  task automatic load_random(input logic [6:0] idx);
    bit wide_range;
    logic [15:0] m;
    wide_range = ($urandom_range(3) == 0);
    m = ($urandom_range(49) == 0) ? 16'd0 : 16'($urandom_range(65535, 1));
    send(KIND_LOAD, idx, rand_coord(wide_range), rand_coord(wide_range),
         32'($signed($urandom) >>> 8), 32'($signed($urandom) >>> 8), m);
  endtask

  // random mix of loads, steps, reads and dropped kinds, loads mostly in the active set
  task automatic run_phase(input int n_items);
    int n, sel, idx;
    n = (m_count > NSLOT) ? NSLOT : int'(m_count);
    for (int s = 0; s < n; s++)
      if (!loaded[s]) load_random(7'(s));
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(99);
      if (sel < 15 && n <= 16) begin
        send(KIND_STEP, 7'($urandom), $urandom, $urandom, $urandom, $urandom, 16'($urandom));
      end else if (sel < 50) begin
        idx = ($urandom_range(9) < 7) ? $urandom_range(n + 1) : $urandom_range(NSLOT - 1);
        load_random(7'(idx));
      end else if (sel < 95) begin
        do idx = $urandom_range(NSLOT - 1); while (!loaded[idx]);
        send(KIND_READ, 7'(idx), $urandom, $urandom, $urandom, $urandom, 16'($urandom));
      end else begin
        send(KIND_UNUSED, 7'($urandom), $urandom, $urandom, $urandom, $urandom,
             16'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  row_t rows[$];

  function automatic void add_row(input logic [1:0] k, input int idx,
                                  input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] vx, input logic [31:0] vy,
                                  input int m, input int typed,
                                  input result_t want);
    row_t r;
    r.it    = '{kind: k, index: 7'(idx), pos_x: x, pos_y: y, vel_x: vx, vel_y: vy,
                mass: 16'(m)};
    r.typed = (typed != 0);
    r.want  = want;
    rows.push_back(r);
  endfunction

  localparam logic [31:0] PMAX = 32'h7fffffff;
  localparam logic [31:0] NMIN = 32'h80000000;
  localparam result_t     STEP_ACK = '{1'b1, 7'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};

  initial begin
    // extremes loaded and read straight back
    add_row(KIND_LOAD, 0, PMAX, PMAX, NMIN, NMIN, 16'hffff, 0, '0);
    add_row(KIND_LOAD, 1, NMIN, NMIN, PMAX, PMAX, 16'd1, 0, '0);
    add_row(KIND_READ, 0, 0, 0, 0, 0, 0, 1, '{1'b0, 7'd0, PMAX, PMAX, NMIN, NMIN});
    add_row(KIND_READ, 1, 0, 0, 0, 0, 0, 1, '{1'b0, 7'd1, NMIN, NMIN, PMAX, PMAX});
    add_row(KIND_UNUSED, 5, PMAX, NMIN, PMAX, NMIN, 16'hffff, 0, '0);  // dropped
    add_row(KIND_STEP, 0, 0, 0, 0, 0, 0, 1, STEP_ACK);  // saturating positions
    add_row(KIND_READ, 0, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_READ, 1, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_LOAD, 127, 0, 32'hffffffff, 1, PMAX, 16'hffff, 0, '0);
    add_row(KIND_READ, 127, 0, 0, 0, 0, 0, 1,
            '{1'b0, 7'd127, 32'sd0, -32'sd1, 32'sd1, PMAX});
    add_row(KIND_LOAD, 2, 32'h10000000, 0, 0, 0, 16'd0, 0, '0);        // zero mass
    add_row(KIND_LOAD, 3, 32'h10001000, 32'h10, 32'h100, 0, 16'd500, 0, '0);
    // a close, heavy pair so the force path and the clamp both show up
    add_row(KIND_LOAD, 0, 0, 0, 0, 0, 16'd1000, 0, '0);
    add_row(KIND_LOAD, 1, 32'h01000000, 32'h00800000, 0, 0, 16'd1000, 0, '0);
    add_row(KIND_STEP, 0, 0, 0, 0, 0, 0, 1, STEP_ACK);
    add_row(KIND_READ, 0, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_READ, 1, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_STEP, 0, 0, 0, 0, 0, 0, 1, STEP_ACK);
    add_row(KIND_READ, 1, 0, 0, 0, 0, 0, 0, '0);
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_idle = 30;
    rx_idle = 84;

    // two active particles, largest scale, no minimum distance
    write_reg(REG_ACTIVE_CNT, 48'd2);
    write_reg(REG_DIST_SCALE, 48'd1024);
    write_reg(REG_GRAV_CONST, 48'hffffffff);
    write_reg(REG_MIN_DIST_SQ, 48'd0);
    foreach (rows[r]) send_item(rows[r].it, rows[r].typed, rows[r].want);

    // zero scale: every pair skipped; full time step drives positions hard
    write_reg(REG_ACTIVE_CNT, 48'd4);
    write_reg(REG_DIST_SCALE, 48'd0);
    write_reg(REG_TIME_STEP, 48'hffffffff);
    run_phase(10);

    write_reg(REG_ACTIVE_CNT, 48'd8);
    write_reg(REG_DIST_SCALE, 48'd100);
    write_reg(REG_MIN_DIST_SQ, 48'd281474977);
    write_reg(REG_GRAV_CONST, 48'd28147498);
    write_reg(REG_FORCE_LIMIT, 48'hffffffffffff);
    write_reg(REG_TIME_STEP, 48'd42949673);
    run_phase(20);

    tx_idle = 84;
    rx_idle = 30;
    // sixteen active, zero force: steps only drift the positions
    write_reg(REG_ACTIVE_CNT, 48'd16);
    write_reg(REG_FORCE_LIMIT, 48'd0);
    write_reg(REG_MIN_DIST_SQ, 48'hffffffff);
    write_reg(REG_GRAV_CONST, 48'd0);
    run_phase(12);

    write_reg(REG_ACTIVE_CNT, 48'd6);
    write_reg(REG_DIST_SCALE, 48'd1);
    write_reg(REG_FORCE_LIMIT, 48'd281474976711);
    write_reg(REG_GRAV_CONST, 48'd1000000);
    write_reg(REG_MIN_DIST_SQ, 48'd0);
    run_phase(20);

    tx_idle = 0;
    rx_idle = 0;
    write_reg(REG_ACTIVE_CNT, 48'd3);
    write_reg(REG_DIST_SCALE, 48'd2047);   // above the cap, acts as 1024
    item_valid <= 1'b0;
    hold_go    <= 1'b1;
    run_phase(20);

    item_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit, several times the slowest correct run
  initial begin
    #50000000;
    $display("status: fail");
    $finish;
  end

endmodule
